FILE: rtl/ccr_pkg.sv
// Shared widths, stage counts and status codes for the circle-center pipeline.
// No dependencies; every rtl file imports this package.
package ccr_pkg;

  localparam int CW = 32;

  localparam int SQ_IN_W   = 66;
  localparam int SQ_OUT_W  = 33;
  localparam int SQ_REM_W  = 35;
  localparam int SQ_STAGES = SQ_OUT_W;
  localparam int SQ_LAT    = SQ_STAGES + 1;

  localparam int DIV_NUM_W  = 65;
  localparam int DIV_DEN_W  = 34;
  localparam int DIV_Q_W    = 33;
  localparam int DIV_STAGES = DIV_Q_W;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOROOT = 2'd1,
    ST_COINC  = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  typedef struct packed {
    logic                 valid;
    logic                 plus;
    logic                 ex_zero;
    logic                 ex_pos;
    logic                 ey_zero;
    logic                 ey_pos;
    logic                 coinc;
    logic                 noroot;
    logic signed [CW-1:0] midx;
    logic signed [CW-1:0] midy;
    logic [CW:0]          aex;
    logic [CW:0]          aey;
  } side_t;

endpackage

FILE: rtl/ccr_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Depends on ccr_pkg for widths and stage count.
module ccr_sqrt_pipe import ccr_pkg::*; (
  input  logic                clk,
  input  logic [SQ_IN_W-1:0]  rad_in,
  output logic [SQ_OUT_W-1:0] root_out
);

  logic [SQ_IN_W-1:0]  rad  [SQ_STAGES+1];
  logic [SQ_REM_W-1:0] rem  [SQ_STAGES+1];
  logic [SQ_OUT_W-1:0] root [SQ_STAGES+1];
  logic [SQ_REM_W:0]   part  [SQ_STAGES];
  logic [SQ_REM_W:0]   trial [SQ_STAGES];
  logic                ge    [SQ_STAGES];

  // bring down two radicand bits, try root*4+1
  always_comb begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      part[i]  = {rem[i][SQ_REM_W-2:0], rad[i][SQ_IN_W-1 -: 2]};
      trial[i] = {1'b0, root[i], 2'b01};
      ge[i]    = part[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    rad[0]  <= rad_in;
    rem[0]  <= '0;
    root[0] <= '0;
    for (int i = 0; i < SQ_STAGES; i++) begin
      rad[i+1]  <= {rad[i][SQ_IN_W-3:0], 2'b00};
      rem[i+1]  <= ge[i] ? SQ_REM_W'(part[i] - trial[i]) : SQ_REM_W'(part[i]);
      root[i+1] <= {root[i][SQ_OUT_W-2:0], ge[i]};
    end
  end

  assign root_out = root[SQ_STAGES];

endmodule

FILE: rtl/ccr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ccr_pkg; quotient must fit DIV_Q_W bits for a meaningful result.
module ccr_div_pipe import ccr_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo
);

  logic [DIV_DEN_W-1:0] rem  [DIV_STAGES+1];
  logic [DIV_Q_W-1:0]   rest [DIV_STAGES+1];
  logic [DIV_DEN_W-1:0] dv   [DIV_STAGES+1];
  logic [DIV_Q_W-1:0]   q    [DIV_STAGES+1];
  logic [DIV_DEN_W:0]   part [DIV_STAGES];
  logic                 ge   [DIV_STAGES];

  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      part[i] = {rem[i], rest[i][DIV_Q_W-1]};
      ge[i]   = part[i] >= {1'b0, dv[i]};
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
    rest[0] <= num[DIV_Q_W-1:0];
    dv[0]   <= den;
    q[0]    <= '0;
    for (int i = 0; i < DIV_STAGES; i++) begin
      rem[i+1]  <= ge[i] ? DIV_DEN_W'(part[i] - {1'b0, dv[i]}) : DIV_DEN_W'(part[i]);
      rest[i+1] <= {rest[i][DIV_Q_W-2:0], 1'b0};
      dv[i+1]   <= dv[i];
      q[i+1]    <= {q[i][DIV_Q_W-2:0], ge[i]};
    end
  end

  assign quo = q[DIV_STAGES];

endmodule

FILE: rtl/circle_center_from_chord_radius.sv
// Top level: circle center from two points and a radius, fully pipelined.
// Depends on ccr_pkg, ccr_sqrt_pipe and ccr_div_pipe.
//
// Give two points and a radius (signed/unsigned Q16.16) with a root selector;
// one result beat comes out on center_x, center_y and status, marked by done
// for a single cycle. busy is always low: a new beat may start in every
// cycle and results leave in the same order, one per cycle. The depth
// is set by the two square roots (an input register, then one root bit per
// stage over 33 stages) followed by the two offset dividers (an input
// register, then one quotient bit per stage over 33 stages). There is no
// backpressure on the result side, so capture every done beat. Status 2 means
// the points coincide and status 1 that the radius is shorter than half the
// chord; both return the midpoint. Status 3 means a coordinate was clamped.
module circle_center_from_chord_radius import ccr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] first_x,
  input  logic signed [CW-1:0] first_y,
  input  logic signed [CW-1:0] second_x,
  input  logic signed [CW-1:0] second_y,
  input  logic [CW-2:0]        radius,
  input  logic                 plus_root,
  output logic                 done,
  output logic signed [CW-1:0] center_x,
  output logic signed [CW-1:0] center_y,
  output logic [1:0]           status
);

  localparam int LINE_LEN = SQ_LAT + DIV_LAT + 3;
  localparam int LAST     = LINE_LEN - 1;
  localparam int LATENCY  = LINE_LEN + 3;

  // never stall: every stage advances every cycle
  assign busy = 1'b0;

  // stage A: capture the beat
  logic                 a_valid, a_plus;
  logic signed [CW-1:0] a_x1, a_y1, a_x2, a_y2;
  logic [CW-2:0]        a_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_x1   <= first_x;
    a_y1   <= first_y;
    a_x2   <= second_x;
    a_y2   <= second_y;
    a_r    <= radius;
    a_plus <= plus_root;
  end

  // stage B: chord vector, its magnitudes and the midpoint
  logic signed [CW:0] ex, ey, sx, sy;
  logic [CW:0]        aex, aey;
  side_t              b_side;
  logic [CW-1:0]      b_r2;

  always_comb begin
    ex  = {a_x2[CW-1], a_x2} - {a_x1[CW-1], a_x1};
    ey  = {a_y2[CW-1], a_y2} - {a_y1[CW-1], a_y1};
    sx  = {a_x2[CW-1], a_x2} + {a_x1[CW-1], a_x1};
    sy  = {a_y2[CW-1], a_y2} + {a_y1[CW-1], a_y1};
    aex = ex[CW] ? (~ex + 1'b1) : ex;
    aey = ey[CW] ? (~ey + 1'b1) : ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side.valid <= 1'b0;
    end else begin
      b_side.valid <= a_valid;
    end
    b_side.plus    <= a_plus;
    b_side.ex_zero <= ex == '0;
    b_side.ex_pos  <= !ex[CW] && (ex != '0);
    b_side.ey_zero <= ey == '0;
    b_side.ey_pos  <= !ey[CW] && (ey != '0);
    b_side.coinc   <= 1'b0;
    b_side.noroot  <= 1'b0;
    // arithmetic shift of the sum is the floor of half
    b_side.midx    <= sx[CW:1];
    b_side.midy    <= sy[CW:1];
    b_side.aex     <= aex;
    b_side.aey     <= aey;
    b_r2           <= {a_r, 1'b0};
  end

  // stage C: squares
  side_t                c_side;
  logic [2*CW+1:0]      c_ex2, c_ey2;
  logic [2*CW-1:0]      c_r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side.valid <= 1'b0;
    end else begin
      c_side.valid <= b_side.valid;
    end
    c_side.plus    <= b_side.plus;
    c_side.ex_zero <= b_side.ex_zero;
    c_side.ex_pos  <= b_side.ex_pos;
    c_side.ey_zero <= b_side.ey_zero;
    c_side.ey_pos  <= b_side.ey_pos;
    c_side.coinc   <= b_side.coinc;
    c_side.noroot  <= b_side.noroot;
    c_side.midx    <= b_side.midx;
    c_side.midy    <= b_side.midy;
    c_side.aex     <= b_side.aex;
    c_side.aey     <= b_side.aey;
    c_ex2          <= b_side.aex * b_side.aex;
    c_ey2          <= b_side.aey * b_side.aey;
    c_r4           <= b_r2 * b_r2;
  end

  // stage D: chord length squared and discriminant; feeds both roots
  logic [SQ_IN_W-1:0] e_sum;
  logic [SQ_IN_W:0]   q_diff;
  side_t              d_side;
  logic [SQ_IN_W-1:0] d_e, d_q;
  side_t              line [LINE_LEN];

  always_comb begin
    e_sum         = c_ex2 + c_ey2;
    q_diff        = {3'b000, c_r4} - {1'b0, e_sum};
    d_side        = c_side;
    d_side.coinc  = e_sum == '0;
    d_side.noroot = q_diff[SQ_IN_W];
  end

  always_ff @(posedge clk) begin
    d_e <= e_sum;
    d_q <= q_diff[SQ_IN_W] ? '0 : q_diff[SQ_IN_W-1:0];
  end

  // sideband shift line, aligned with the arithmetic path
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        line[i] <= '0;
      end
    end else begin
      line[0] <= d_side;
      for (int i = 1; i < LINE_LEN; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  logic [SQ_OUT_W-1:0] root_l, root_h;

  ccr_sqrt_pipe u_sqrt_len (
    .clk      (clk),
    .rad_in   (d_e),
    .root_out (root_l)
  );

  ccr_sqrt_pipe u_sqrt_disc (
    .clk      (clk),
    .rad_in   (d_q),
    .root_out (root_h)
  );

  // M1: offset products; M2: add half divisor for round-half-up
  side_t               s_side;
  logic [2*CW+1:0]     m1_px, m1_py;
  logic [SQ_OUT_W-1:0] m1_l;
  logic [DIV_NUM_W-1:0] m2_nx, m2_ny;
  logic [DIV_DEN_W-1:0] m2_den;
  logic [2*CW+1:0]      sum_x, sum_y;

  assign s_side = line[SQ_LAT];

  always_ff @(posedge clk) begin
    m1_px <= s_side.aey * root_h;
    m1_py <= s_side.aex * root_h;
    m1_l  <= root_l;
  end

  always_comb begin
    sum_x = m1_px + (2*CW+2)'(m1_l);
    sum_y = m1_py + (2*CW+2)'(m1_l);
  end

  always_ff @(posedge clk) begin
    m2_nx  <= sum_x[DIV_NUM_W-1:0];
    m2_ny  <= sum_y[DIV_NUM_W-1:0];
    m2_den <= {m1_l, 1'b0};
  end

  logic [DIV_Q_W-1:0] mx, my;

  ccr_div_pipe u_div_x (
    .clk (clk),
    .num (m2_nx),
    .den (m2_den),
    .quo (mx)
  );

  ccr_div_pipe u_div_y (
    .clk (clk),
    .num (m2_ny),
    .den (m2_den),
    .quo (my)
  );

  // final stage: place the offset, clamp, pick status
  side_t               f_side;
  logic signed [CW+2:0] off_x, off_y, cx, cy;
  logic                 neg_x, neg_y, zero_x, sat_hi_x, sat_lo_x, sat_hi_y, sat_lo_y;
  logic signed [CW-1:0] cx_clamp, cy_clamp;
  status_t              st;
  localparam logic [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

  assign f_side = line[LAST];

  always_comb begin
    off_x = (CW+3)'(mx);
    off_y = (CW+3)'(my);
    zero_x = 1'b0;
    neg_y  = !f_side.plus;
    if (f_side.ex_zero) begin
      neg_x = !f_side.plus;
      off_y = '0;
    end else begin
      zero_x = f_side.ey_zero;
      // offset in x runs against the sign of ey when the root follows ex
      neg_x  = ((f_side.plus == f_side.ex_pos) == f_side.ey_pos);
    end
    if (zero_x) begin
      off_x = '0;
    end
    cx = {{3{f_side.midx[CW-1]}}, f_side.midx} + (neg_x ? -off_x : off_x);
    cy = {{3{f_side.midy[CW-1]}}, f_side.midy} + (neg_y ? -off_y : off_y);
    sat_hi_x = !cx[CW+2] && (cx[CW+1:CW-1] != 3'b000);
    sat_lo_x =  cx[CW+2] && (cx[CW+1:CW-1] != 3'b111);
    sat_hi_y = !cy[CW+2] && (cy[CW+1:CW-1] != 3'b000);
    sat_lo_y =  cy[CW+2] && (cy[CW+1:CW-1] != 3'b111);
    cx_clamp = sat_hi_x ? MAX_C : (sat_lo_x ? MIN_C : cx[CW-1:0]);
    cy_clamp = sat_hi_y ? MAX_C : (sat_lo_y ? MIN_C : cy[CW-1:0]);
    if (f_side.coinc) begin
      st       = ST_COINC;
      cx_clamp = f_side.midx;
      cy_clamp = f_side.midy;
    end else if (f_side.noroot) begin
      st       = ST_NOROOT;
      cx_clamp = f_side.midx;
      cy_clamp = f_side.midy;
    end else if (sat_hi_x || sat_lo_x || sat_hi_y || sat_lo_y) begin
      st = ST_SAT;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_side.valid;
    end
    center_x <= cx_clamp;
    center_y <= cy_clamp;
    status   <= st;
  end

  // every accepted beat gives exactly one result
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(LATENCY+1) done)
    else $error("accepted beat gave no result at the expected cycle");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY+1))
    else $error("result without a matching accepted beat");

  a_coinc_point: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_COINC) |->
      (center_x == $past(first_x, LATENCY+1)) && (center_y == $past(first_y, LATENCY+1)))
    else $error("coincident points did not return the point");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_SAT) |->
      (center_x == MAX_C) || (center_x == MIN_C) || (center_y == MAX_C) || (center_y == MIN_C))
    else $error("saturated status without a clamped coordinate");

endmodule
